/* hw/rtl/folded_seed_mt64_keystream_top_macros.svh */
// assertion macros for the keystream block
`ifndef FOLDED_SEED_MT64_KEYSTREAM_TOP_MACROS_SVH
`define FOLDED_SEED_MT64_KEYSTREAM_TOP_MACROS_SVH
// implication checked on every clock unless in reset
`define FSK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FSK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/fsk_pkg.sv */
// shared types and constants for the keystream block
`default_nettype none
package fsk_pkg;
    localparam int unsigned MtN = 312;
    localparam int unsigned MtM = 156;
    localparam logic [63:0] FoldInit = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KeyMix = 64'hCEAC_3B5A_8678_37AC;
    localparam logic [63:0] MtMult = 64'd6364136223846793005;
    localparam logic [63:0] MtMatrix = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] MtUpper = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MtLower = 64'h0000_0000_7FFF_FFFF;

    localparam logic [1:0] ModeAbsorb = 2'd0;
    localparam logic [1:0] ModeSeed = 2'd1;
    localparam logic [1:0] ModeDraw = 2'd2;

    typedef enum logic [0:0] {
        t_cmd_seed = 1'b0,
        t_cmd_draw = 1'b1
    } t_cmd;

    // queued command: seed value or draw request
    typedef struct packed {
        t_cmd        cmd;
        logic        unseeded;
        logic [63:0] seed;
    } t_job;

    typedef enum logic [2:0] {
        t_st_idle,
        t_st_seed_mul,
        t_st_seed_mul_hi,
        t_st_seed_mul_cr,
        t_st_seed_wr,
        t_st_rd,
        t_st_calc,
        t_st_out
    } t_state;

    function automatic logic [63:0] temper(input logic [63:0] yi);
        logic [63:0] y;
        y = yi;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/fsk_front.sv */
// front end: fold absorb and command classification
`default_nettype none
module fsk_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_mode,
    input  wire logic [63:0]   i_data_word,
    input  wire logic [63:0]   i_key_low,
    input  wire logic [63:0]   i_key_high,
    output logic               o_push,
    output fsk_pkg::t_job      o_job,
    input  wire logic          i_full
);
    logic [63:0] r_fold;
    logic        r_seeded;
    logic        w_acc;

    assign o_ready = !i_full;
    assign w_acc = i_valid && o_ready;
    assign o_push = w_acc && (i_mode == fsk_pkg::ModeSeed || i_mode == fsk_pkg::ModeDraw);

    always_comb begin
        o_job.cmd = (i_mode == fsk_pkg::ModeSeed) ? fsk_pkg::t_cmd_seed : fsk_pkg::t_cmd_draw;
        o_job.unseeded = !r_seeded;
        o_job.seed = i_key_high ^ fsk_pkg::KeyMix ^ r_fold ^ i_key_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= fsk_pkg::FoldInit;
            r_seeded <= 1'b0;
        end else if (w_acc) begin
            case (i_mode)
                fsk_pkg::ModeAbsorb: r_fold <= r_fold ^ i_data_word;
                fsk_pkg::ModeSeed: begin
                    r_fold <= fsk_pkg::FoldInit;
                    r_seeded <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/fsk_queue.sv */
// two-entry command queue between front and back
`default_nettype none
module fsk_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fsk_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output fsk_pkg::t_job      o_job
);
    fsk_pkg::t_job r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/fsk_back.sv */
// back end: twister state memory, seeding walk, twist and tempering
`default_nettype none
module fsk_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_empty,
    input  wire fsk_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [63:0]        o_random_word,
    output logic               o_not_seeded
);
    localparam logic [8:0] LastIdx = 9'(fsk_pkg::MtN - 1);

    logic [63:0] r_mem [fsk_pkg::MtN];
    fsk_pkg::t_state r_state, n_state;
    logic [8:0]  r_idx;      // twister index
    logic [8:0]  r_si;       // seeding position
    logic [63:0] r_prev;
    logic [63:0] r_prod;
    logic [63:0] r_rd_a, r_rd_b;
    logic [63:0] r_word;
    logic        r_unseeded;
    logic        r_ovalid;
    logic [63:0] r_cur;
    logic [8:0]  w_nxt, w_far, w_addr_a, w_addr_b;
    logic        w_we;
    logic [8:0]  w_waddr;
    logic [63:0] w_wdata, w_x, w_y;
    logic        w_can_out;
    logic [63:0] w_mix;
    logic [31:0] w_opa, w_opb;
    logic [63:0] w_pp;

    assign w_nxt = (r_idx == LastIdx) ? 9'd0 : r_idx + 9'd1;
    assign w_far = (r_idx >= 9'(fsk_pkg::MtM)) ? r_idx - 9'(fsk_pkg::MtM)
                                                : r_idx + 9'(fsk_pkg::MtM);
    assign w_can_out = !r_ovalid || i_tready;
    assign o_tvalid = r_ovalid;

    // ports: a reads cur in idle and far in rd, b reads nxt
    assign w_addr_a = (r_state == fsk_pkg::t_st_rd) ? w_far : r_idx;
    assign w_addr_b = w_nxt;

    // low 64 bits of the seeding product from three 32x32 partial products
    assign w_mix = r_prev ^ (r_prev >> 62);
    assign w_opa = (r_state == fsk_pkg::t_st_seed_mul_hi) ? w_mix[63:32] : w_mix[31:0];
    assign w_opb = (r_state == fsk_pkg::t_st_seed_mul_cr) ? fsk_pkg::MtMult[63:32]
                                                          : fsk_pkg::MtMult[31:0];
    assign w_pp = 64'(w_opa) * 64'(w_opb);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    assign w_x = (r_cur & fsk_pkg::MtUpper) | (r_rd_b & fsk_pkg::MtLower);
    assign w_y = r_rd_a ^ (w_x >> 1) ^ (w_x[0] ? fsk_pkg::MtMatrix : 64'd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsk_pkg::t_st_idle:
                if (!i_empty) begin
                    if (i_job.cmd == fsk_pkg::t_cmd_seed) n_state = fsk_pkg::t_st_seed_mul;
                    else if (i_job.unseeded) n_state = fsk_pkg::t_st_out;
                    else n_state = fsk_pkg::t_st_rd;
                end
            fsk_pkg::t_st_seed_mul: n_state = fsk_pkg::t_st_seed_mul_hi;
            fsk_pkg::t_st_seed_mul_hi: n_state = fsk_pkg::t_st_seed_mul_cr;
            fsk_pkg::t_st_seed_mul_cr: n_state = fsk_pkg::t_st_seed_wr;
            fsk_pkg::t_st_seed_wr:
                n_state = (r_si == LastIdx) ? fsk_pkg::t_st_idle : fsk_pkg::t_st_seed_mul;
            fsk_pkg::t_st_rd: n_state = fsk_pkg::t_st_calc;
            fsk_pkg::t_st_calc: n_state = fsk_pkg::t_st_out;
            fsk_pkg::t_st_out: if (w_can_out) n_state = fsk_pkg::t_st_idle;
            default: n_state = fsk_pkg::t_st_idle;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        w_we = 1'b0;
        w_waddr = r_si;
        w_wdata = r_prod + 64'(r_si);
        case (r_state)
            fsk_pkg::t_st_idle: begin
                o_pop = !i_empty;
                w_we = !i_empty && i_job.cmd == fsk_pkg::t_cmd_seed;
                w_waddr = 9'd0;
                w_wdata = i_job.seed;
            end
            fsk_pkg::t_st_seed_wr: w_we = 1'b1;
            fsk_pkg::t_st_calc: begin
                w_we = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_y;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsk_pkg::t_st_idle;
            r_idx <= 9'd0;
            r_si <= 9'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fsk_pkg::t_st_out && w_can_out) r_ovalid <= 1'b1;
            else if (i_tready) r_ovalid <= 1'b0;
            case (r_state)
                fsk_pkg::t_st_idle:
                    if (!i_empty) begin
                        r_unseeded <= i_job.unseeded;
                        if (i_job.cmd == fsk_pkg::t_cmd_seed) begin
                            r_prev <= i_job.seed;
                            r_si <= 9'd1;
                            r_idx <= 9'd0;
                        end else begin
                            r_word <= 64'd0;
                        end
                    end
                fsk_pkg::t_st_seed_mul:
                    r_prod <= w_pp;
                fsk_pkg::t_st_seed_mul_hi, fsk_pkg::t_st_seed_mul_cr:
                    r_prod[63:32] <= r_prod[63:32] + w_pp[31:0];
                fsk_pkg::t_st_seed_wr: begin
                    r_prev <= w_wdata;
                    r_si <= r_si + 9'd1;
                end
                fsk_pkg::t_st_rd:
                    r_cur <= r_rd_a;
                fsk_pkg::t_st_calc: begin
                    r_word <= fsk_pkg::temper(w_y);
                    r_idx <= w_nxt;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fsk_pkg::t_st_out && w_can_out) begin
            o_random_word <= r_word;
            o_not_seeded <= r_unseeded;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/folded_seed_mt64_keystream_top.sv */
// top level of the folded-seed 64-bit twister keystream block
// channel  | dir | fields
// s_axis   | in  | tdata: mode[1:0], data_word[65:2]
// m_axis   | out | tdata: random_word[63:0], not_seeded[64]
// cfg      | in  | index 0 key_low, 1 key_high
// absorb is handled in the front alone and never enters the queue
// a draw passes the back states idle (pop, cur/nxt read), rd (far read), calc (twist and
// write-back) and out (output load, waits on stall); an unseeded draw goes idle to out
// a seed writes word 0 on pop, then 311 words, each via the seed_mul states and seed_wr
// reset is synchronous active low; the word memory is not cleared
// the two-entry queue lets the front absorb words while the back is busy
`default_nettype none
`include "folded_seed_mt64_keystream_top_macros.svh"
module folded_seed_mt64_keystream_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // mode[1:0], data_word[65:2]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // random_word[63:0], not_seeded[64]
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [63:0] r_key_low, r_key_high;
    logic        w_push, w_full, w_pop, w_empty;
    fsk_pkg::t_job w_job_in, w_job_out;
    logic [63:0] w_rw;
    logic        w_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low <= 64'd0;
            r_key_high <= 64'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index) r_key_high <= i_cfg_data;
            else r_key_low <= i_cfg_data;
        end
    end

    fsk_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tdata[1:0]), .i_data_word(s_axis_tdata[65:2]),
        .i_key_low(r_key_low), .i_key_high(r_key_high),
        .o_push(w_push), .o_job(w_job_in), .i_full(w_full)
    );

    fsk_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_job(w_job_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_job(w_job_out)
    );

    fsk_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_job(w_job_out), .o_pop(w_pop),
        .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_random_word(w_rw), .o_not_seeded(w_ns)
    );

    assign m_axis_tdata = {7'd0, w_ns, w_rw};

    `FSK_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_full, !w_push, "push into full queue")
    `FSK_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_empty, !w_pop, "pop from empty queue")
    `FSK_ASSERT_IMP(a_unseeded_zero, i_clk, i_rst_n, m_axis_tvalid && w_ns, w_rw == 64'd0,
        "unseeded draw gave nonzero word")
endmodule
`default_nettype wire

/* sim/fsk_checker.sv */
// stream checker for the keystream block: tracks its state and compares every output word
`timescale 1ns / 1ps
module fsk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic        unseeded;
        logic [63:0] word;
    } t_draw_out;

    logic [63:0] key_lo, key_hi, fold_acc;
    logic [63:0] mt_state [fsk_pkg::MtN];
    int unsigned mt_pos;
    logic        have_seed;
    t_draw_out   draws_due [$];

    initial begin
        key_lo = '0;
        key_hi = '0;
        fold_acc = fsk_pkg::FoldInit;
        mt_pos = 0;
        have_seed = 1'b0;
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_fail_count++;
    endtask

    function automatic logic [63:0] mt_temper(input logic [63:0] v);
        logic [63:0] y;
        y = v;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        return y ^ (y >> 43);
    endfunction

    task automatic mt_seed(input logic [63:0] s);
        logic [63:0] p;
        mt_state[0] = s;
        for (int i = 1; i < fsk_pkg::MtN; i++) begin
            p = mt_state[i-1];
            mt_state[i] = fsk_pkg::MtMult * (p ^ (p >> 62)) + 64'(i);
        end
        mt_pos = 0;
    endtask

    task automatic mt_next(output logic [63:0] r);
        int unsigned nx, fr;
        logic [63:0] x, xa;
        nx = (mt_pos + 1) % fsk_pkg::MtN;
        fr = (mt_pos + fsk_pkg::MtM) % fsk_pkg::MtN;
        x = (mt_state[mt_pos] & fsk_pkg::MtUpper) | (mt_state[nx] & fsk_pkg::MtLower);
        xa = x >> 1;
        if (x[0]) begin
            xa = xa ^ fsk_pkg::MtMatrix;
        end
        mt_state[mt_pos] = mt_state[fr] ^ xa;
        r = mt_temper(mt_state[mt_pos]);
        mt_pos = nx;
    endtask

    // sample at the falling edge: handshake values are stable until the next rising edge
    always @(negedge i_clk) begin
        logic [1:0]  md;
        logic [63:0] dw, r;
        t_draw_out   e;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) key_lo = i_cfg_data;
                else key_hi = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                md = s_axis_tdata[1:0];
                dw = s_axis_tdata[65:2];
                if (md == fsk_pkg::ModeAbsorb) begin
                    fold_acc = fold_acc ^ dw;
                end else if (md == fsk_pkg::ModeSeed) begin
                    mt_seed(key_hi ^ fsk_pkg::KeyMix ^ fold_acc ^ key_lo);
                    fold_acc = fsk_pkg::FoldInit;
                    have_seed = 1'b1;
                end else if (md == fsk_pkg::ModeDraw) begin
                    if (!have_seed) begin
                        draws_due.push_back('{unseeded: 1'b1, word: '0});
                    end else begin
                        mt_next(r);
                        draws_due.push_back('{unseeded: 1'b0, word: r});
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (draws_due.size() == 0) begin
                    report("unexpected word", m_axis_tdata[63:0], '0);
                end else begin
                    e = draws_due.pop_front();
                    if (m_axis_tdata[63:0] !== e.word)
                        report("random_word", m_axis_tdata[63:0], e.word);
                    if (m_axis_tdata[64] !== e.unseeded)
                        report("not_seeded", 64'(m_axis_tdata[64]), 64'(e.unseeded));
                end
            end
            o_pending = draws_due.size();
        end
    end
endmodule

/* sim/tb.sv */
// testbench top for the keystream block: stimulus, key phases and verdict
`timescale 1ns / 1ps
module tb;
    localparam int SeedDrain = 2600;
    localparam int CycleLimit = 600000;
    localparam logic [1:0] ModeUnused = 2'd3;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we, i_cfg_index;
    logic [63:0] i_cfg_data;
    int          fail_count, pending;
    bit          no_idle;
    int          hold_trig, hold_seen, hold_left;
    int          n_items, n_draws, n_seeds, n_phases;
    int          cycles;

    folded_seed_mt64_keystream_top dut (.*);

    fsk_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("timeout after %0d cycles", cycles);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_trig != hold_seen) begin
                hold_seen = hold_trig;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 14);
            end
        end
    end

    task automatic send_word(input logic [1:0] md, input logic [63:0] dw);
        bit rdy;
        if (!no_idle && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, dw, md};
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        n_items++;
        if (md == fsk_pkg::ModeDraw) n_draws++;
        if (md == fsk_pkg::ModeSeed) n_seeds++;
    endtask

    // sender pause: all words back, then let a possible seed walk finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SeedDrain) @(posedge i_clk);
    endtask

    task automatic set_keys(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 1'b0;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_index <= 1'b1;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_phases++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] klo, khi;
        int r;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        no_idle = 1'b0;
        hold_trig = 0;
        n_items = 0; n_draws = 0; n_seeds = 0; n_phases = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: draw before seed, unused mode, fold extremes, reseed
        send_word(fsk_pkg::ModeDraw, '0);
        send_word(ModeUnused, '1);
        send_word(fsk_pkg::ModeDraw, '1);
        send_word(fsk_pkg::ModeAbsorb, '0);
        send_word(fsk_pkg::ModeAbsorb, '1);
        send_word(fsk_pkg::ModeAbsorb, 64'h5555_5555_5555_5555);
        send_word(fsk_pkg::ModeAbsorb, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(fsk_pkg::ModeSeed, '1);
        repeat (4) send_word(fsk_pkg::ModeDraw, '0);
        send_word(fsk_pkg::ModeSeed, '0);
        send_word(fsk_pkg::ModeSeed, '0);
        send_word(ModeUnused, 64'h5555_5555_5555_5555);
        repeat (3) send_word(fsk_pkg::ModeDraw, rand64());
        drain();
        set_keys('1, '1);
        send_word(fsk_pkg::ModeSeed, '0);
        repeat (4) send_word(fsk_pkg::ModeDraw, '0);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin klo = '0; khi = '1; end
                1: begin klo = '1; khi = '0; end
                2: begin klo = '0; khi = '0; end
                default: begin klo = rand64(); khi = rand64(); end
            endcase
            set_keys(klo, khi);
            send_word(fsk_pkg::ModeSeed, '0);
            for (int k = 0; k < 220; k++) begin
                if (ph == 2) no_idle = (k >= 20 && k < 180);
                if (ph == 3 && k == 30) hold_trig++;
                r = $urandom_range(99);
                if (r < 2) send_word(fsk_pkg::ModeSeed, rand64());
                else if (r < 5) send_word(ModeUnused, rand64());
                else if (r < 40) send_word(fsk_pkg::ModeAbsorb, rand64());
                else send_word(fsk_pkg::ModeDraw, rand64());
            end
            no_idle = 1'b0;
        end
        drain();

        $display("%0d words sent: %0d draws, %0d seeds, %0d key settings",
                 n_items, n_draws, n_seeds, n_phases);
        $display("includes unseeded draws, unused mode, reseeds, long output stall");
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fsk_pkg.sv
hw/rtl/fsk_front.sv
hw/rtl/fsk_queue.sv
hw/rtl/fsk_back.sv
hw/rtl/folded_seed_mt64_keystream_top.sv
sim/fsk_checker.sv
sim/tb.sv
